FILE: rtl/hcbd_pkg.sv
// Shared types and constants for the HTTP chunked body decoder.
package hcbd_pkg;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_EXT     = 3'd1,
        PH_SIZE_LF = 3'd2,
        PH_DATA    = 3'd3,
        PH_DATA_CR = 3'd4,
        PH_DATA_LF = 3'd5,
        PH_DONE    = 3'd6,
        PH_ERROR   = 3'd7
    } phase_t;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PAYLOAD  = 2'd0;
    localparam kind_t KIND_COMPLETE = 2'd1;
    localparam kind_t KIND_FRAMING  = 2'd2;
    localparam kind_t KIND_OVERFLOW = 2'd3;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    localparam logic [2:0] ADDR_STRICT_CRLF = 3'd0;

    // Returns {is_hex, value} for one ASCII byte.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            r = {1'b1, 4'(c - 8'd48)};
        end else if (c >= 8'd97 && c <= 8'd102) begin
            r = {1'b1, 4'(c - 8'd87)};
        end else if (c >= 8'd65 && c <= 8'd70) begin
            r = {1'b1, 4'(c - 8'd55)};
        end
        return r;
    endfunction

endpackage

FILE: rtl/http_chunked_body_decoder_top.sv
// Results are registered: an accepted item passes the input register, then the result register.
// Throughput: one byte per cycle while the result register is free; one parse pass per byte.
// Bytes that produce no result still wait for a free result register to leave the input register.
// Reset: aresetn is synchronous and active low; it clears the parse phase to the size digits,
// the size count, strict_crlf and both valid flags.
module http_chunked_body_decoder_top #(
    parameter int LEN_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [0:0]  s_tuser,    // [0] msg_start
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic [1:0]  m_tuser,    // [1:0] out_kind
    output logic        m_tlast     // chunk_last
);

    logic                    strict_reg;
    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_msg_reg;
    hcbd_pkg::phase_t        phase_reg, phase_next, cur_phase;
    logic [LEN_BITS-1:0]     count_reg, count_next, cur_count, count_dec, count_shift;
    logic                    m_valid_reg;
    logic [7:0]              m_byte_reg;
    hcbd_pkg::kind_t         m_kind_reg;
    logic                    m_last_reg;

    logic                    out_free;
    logic                    advance;
    logic [4:0]              hex;
    logic                    is_hex;
    logic                    size_ovf;
    logic                    emit;
    hcbd_pkg::kind_t         emit_kind;
    logic [7:0]              emit_byte;
    logic                    emit_last;

    // Configuration
    assign pready = 1'b1;
    assign prdata = (paddr == hcbd_pkg::ADDR_STRICT_CRLF) ? {31'd0, strict_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr == hcbd_pkg::ADDR_STRICT_CRLF) begin
            strict_reg <= pwdata[0];
        end
    end

    // Handshake: the input register moves on whenever the result register is free.
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_msg_reg  <= s_tuser[0];
        end
    end

    // A message start clears the parser before this byte is looked at.
    always_comb begin
        cur_phase   = in_msg_reg ? hcbd_pkg::PH_SIZE : phase_reg;
        cur_count   = in_msg_reg ? '0 : count_reg;
        hex         = hcbd_pkg::hex_digit(in_byte_reg);
        is_hex      = hex[4];
        size_ovf    = (cur_count[LEN_BITS-1 -: 4] != 4'd0);
        count_shift = {cur_count[LEN_BITS-5:0], hex[3:0]};
        count_dec   = cur_count - LEN_BITS'(1);
    end

    // Next state
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (advance) begin
            phase_next = cur_phase;
            count_next = cur_count;
            case (cur_phase)
                hcbd_pkg::PH_SIZE, hcbd_pkg::PH_EXT: begin
                    if (cur_phase == hcbd_pkg::PH_SIZE && is_hex) begin
                        if (size_ovf) begin
                            phase_next = hcbd_pkg::PH_ERROR;
                        end else begin
                            count_next = count_shift;
                        end
                    end else if (in_byte_reg == hcbd_pkg::CH_CR) begin
                        phase_next = (cur_count == '0) ? hcbd_pkg::PH_DONE
                                                       : hcbd_pkg::PH_SIZE_LF;
                    end else begin
                        phase_next = hcbd_pkg::PH_EXT;
                    end
                end
                hcbd_pkg::PH_SIZE_LF: begin
                    phase_next = (strict_reg && in_byte_reg != hcbd_pkg::CH_LF)
                                 ? hcbd_pkg::PH_ERROR : hcbd_pkg::PH_DATA;
                end
                hcbd_pkg::PH_DATA: begin
                    count_next = count_dec;
                    if (count_dec == '0) begin
                        phase_next = hcbd_pkg::PH_DATA_CR;
                    end
                end
                hcbd_pkg::PH_DATA_CR: begin
                    phase_next = (strict_reg && in_byte_reg != hcbd_pkg::CH_CR)
                                 ? hcbd_pkg::PH_ERROR : hcbd_pkg::PH_DATA_LF;
                end
                hcbd_pkg::PH_DATA_LF: begin
                    if (strict_reg && in_byte_reg != hcbd_pkg::CH_LF) begin
                        phase_next = hcbd_pkg::PH_ERROR;
                    end else begin
                        phase_next = hcbd_pkg::PH_SIZE;
                        count_next = '0;
                    end
                end
                default: begin
                    phase_next = cur_phase;
                end
            endcase
        end
    end

    // Result for the byte in the input register
    always_comb begin
        emit      = 1'b0;
        emit_kind = hcbd_pkg::KIND_PAYLOAD;
        emit_byte = 8'd0;
        emit_last = 1'b0;
        case (cur_phase)
            hcbd_pkg::PH_SIZE, hcbd_pkg::PH_EXT: begin
                if (cur_phase == hcbd_pkg::PH_SIZE && is_hex) begin
                    if (size_ovf) begin
                        emit      = 1'b1;
                        emit_kind = hcbd_pkg::KIND_OVERFLOW;
                    end
                end else if (in_byte_reg == hcbd_pkg::CH_CR && cur_count == '0) begin
                    emit      = 1'b1;
                    emit_kind = hcbd_pkg::KIND_COMPLETE;
                end
            end
            hcbd_pkg::PH_SIZE_LF, hcbd_pkg::PH_DATA_LF: begin
                if (strict_reg && in_byte_reg != hcbd_pkg::CH_LF) begin
                    emit      = 1'b1;
                    emit_kind = hcbd_pkg::KIND_FRAMING;
                end
            end
            hcbd_pkg::PH_DATA: begin
                emit      = 1'b1;
                emit_byte = in_byte_reg;
                emit_last = (count_dec == '0);
            end
            hcbd_pkg::PH_DATA_CR: begin
                if (strict_reg && in_byte_reg != hcbd_pkg::CH_CR) begin
                    emit      = 1'b1;
                    emit_kind = hcbd_pkg::KIND_FRAMING;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= hcbd_pkg::PH_SIZE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            if (out_free) begin
                m_valid_reg <= advance && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_byte_reg <= emit_byte;
            m_kind_reg <= emit_kind;
            m_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // While payload flows, at least one byte is still owed.
    a_data_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == hcbd_pkg::PH_DATA |-> count_reg != '0)
        else $error("payload phase with zero remaining count");

    // A chunk end mark only ever comes with a payload byte.
    a_last_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == hcbd_pkg::KIND_PAYLOAD)
        else $error("chunk_last on a non-payload result");

    // A finished or failed message stays silent until a new message starts.
    a_silent_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (cur_phase == hcbd_pkg::PH_DONE || cur_phase == hcbd_pkg::PH_ERROR)
        |=> !$rose(m_tvalid))
        else $error("result produced after message end");

    // Payload results come only from the payload phase.
    a_payload_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && emit && emit_kind == hcbd_pkg::KIND_PAYLOAD
        |-> cur_phase == hcbd_pkg::PH_DATA)
        else $error("payload result outside the payload phase");
`endif

endmodule

FILE: test/http_chunked_body_decoder_top_tb.sv
// Self-checking testbench for the HTTP chunked body decoder: directed rows, then random messages.
module http_chunked_body_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]      data;
        hcbd_pkg::kind_t kind;
        logic            last;
    } chunk_res_t;

    typedef enum logic [1:0] {CFG_KEEP, CFG_LAX, CFG_STRICT} cfg_op_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RES} chk_t;

    typedef struct packed {
        cfg_op_t    cfg;
        logic [7:0] b;
        logic       st;
        chk_t       chk;
        chunk_res_t res;
    } stim_row_t;

    localparam chunk_res_t NO_RES = '0;
    localparam chunk_res_t DONE_RES = '{8'h00, hcbd_pkg::KIND_COMPLETE, 1'b0};

    // Directed rows: a chunk whose size line holds a bare LF and an extension, the
    // payload extremes, the terminating zero chunk, an empty size line, an oversized
    // size, a byte ignored after the error, and a strict-mode LF mismatch.
    localparam stim_row_t DIRECTED_TBL [25] = '{
        '{CFG_KEEP,   "2",   1'b1, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   hcbd_pkg::CH_LF, 1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   ";",   1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   hcbd_pkg::CH_CR, 1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   hcbd_pkg::CH_LF, 1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   8'h00, 1'b0, CHK_RES,   '{8'h00, hcbd_pkg::KIND_PAYLOAD, 1'b0}},
        '{CFG_KEEP,   8'hFF, 1'b0, CHK_RES,   '{8'hFF, hcbd_pkg::KIND_PAYLOAD, 1'b1}},
        '{CFG_KEEP,   hcbd_pkg::CH_CR, 1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   hcbd_pkg::CH_LF, 1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   "0",   1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   hcbd_pkg::CH_CR, 1'b0, CHK_RES,   DONE_RES},
        '{CFG_KEEP,   hcbd_pkg::CH_CR, 1'b1, CHK_RES,   DONE_RES},
        '{CFG_KEEP,   "F",   1'b1, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   "f",   1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   "e",   1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   "d",   1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   "c",   1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   "B",   1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   "A",   1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   "9",   1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   "0",   1'b0, CHK_RES,   '{8'h00, hcbd_pkg::KIND_OVERFLOW, 1'b0}},
        '{CFG_KEEP,   "Z",   1'b0, CHK_NONE,  NO_RES},
        '{CFG_STRICT, "1",   1'b1, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   hcbd_pkg::CH_CR, 1'b0, CHK_MODEL, NO_RES},
        '{CFG_KEEP,   "X",   1'b0, CHK_RES,   '{8'h00, hcbd_pkg::KIND_FRAMING, 1'b0}}
    };

    localparam int SEND_IDLE [5] = '{0, 48, 0, 27, 0};
    localparam int RECV_STALL [5] = '{0, 0, 48, 27, 0};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] data_byte
    logic [0:0]  s_tuser = '0;    // [0] msg_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] out_byte
    logic [1:0]  m_tuser;         // [1:0] out_kind
    logic        m_tlast;         // chunk_last

    // Predictor state, kept in step with the accepted items.
    hcbd_pkg::phase_t pred_phase = hcbd_pkg::PH_SIZE;
    logic [31:0]      pred_count = '0;
    logic             pred_strict = 1'b0;

    chunk_res_t  due_results [$];
    int          err_cnt = 0;
    int          sent_cnt = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cnt = 0;
    logic        hold_req = 1'b0;
    chk_t        row_chk = CHK_MODEL;
    chunk_res_t  row_res = '0;

    http_chunked_body_decoder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Advances the decoder state by one byte; returns 1 when the byte yields a result.
    function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                       output chunk_res_t r);
        int         hv;
        logic [7:0] want_b;
        r = '0;
        hv = -1;
        if (b >= 8'h30 && b <= 8'h39) hv = b - 8'h30;
        else if (b >= 8'h61 && b <= 8'h66) hv = b - 8'h57;
        else if (b >= 8'h41 && b <= 8'h46) hv = b - 8'h37;
        if (st) begin
            pred_phase = hcbd_pkg::PH_SIZE;
            pred_count = '0;
        end
        case (pred_phase)
            hcbd_pkg::PH_SIZE, hcbd_pkg::PH_EXT: begin
                if (pred_phase == hcbd_pkg::PH_SIZE && hv >= 0) begin
                    if (pred_count[31:28] != 4'd0) begin
                        pred_phase = hcbd_pkg::PH_ERROR;
                        r.kind = hcbd_pkg::KIND_OVERFLOW;
                        return 1'b1;
                    end
                    pred_count = {pred_count[27:0], 4'(hv)};
                    return 1'b0;
                end
                if (b != hcbd_pkg::CH_CR) begin
                    pred_phase = hcbd_pkg::PH_EXT;
                end else if (pred_count != 0) begin
                    pred_phase = hcbd_pkg::PH_SIZE_LF;
                end else begin
                    pred_phase = hcbd_pkg::PH_DONE;
                    r.kind = hcbd_pkg::KIND_COMPLETE;
                    return 1'b1;
                end
            end
            hcbd_pkg::PH_SIZE_LF, hcbd_pkg::PH_DATA_CR, hcbd_pkg::PH_DATA_LF: begin
                want_b = (pred_phase == hcbd_pkg::PH_DATA_CR) ? hcbd_pkg::CH_CR
                                                              : hcbd_pkg::CH_LF;
                if (pred_strict && b != want_b) begin
                    pred_phase = hcbd_pkg::PH_ERROR;
                    r.kind = hcbd_pkg::KIND_FRAMING;
                    return 1'b1;
                end
                if (pred_phase == hcbd_pkg::PH_SIZE_LF) begin
                    pred_phase = hcbd_pkg::PH_DATA;
                end else if (pred_phase == hcbd_pkg::PH_DATA_CR) begin
                    pred_phase = hcbd_pkg::PH_DATA_LF;
                end else begin
                    pred_phase = hcbd_pkg::PH_SIZE;
                    pred_count = '0;
                end
            end
            hcbd_pkg::PH_DATA: begin
                pred_count = pred_count - 1;
                r.data = b;
                r.kind = hcbd_pkg::KIND_PAYLOAD;
                r.last = (pred_count == 0);
                if (r.last) pred_phase = hcbd_pkg::PH_DATA_CR;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic note_mismatch(input string what, input chunk_res_t want,
                                 input chunk_res_t got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t: %s: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
                     $time, what, want.data, want.kind, want.last, got.data, got.kind, got.last);
    endtask

    // Offers one item, waits for the handshake, then records what it should produce.
    task automatic push_byte(input logic [7:0] b, input logic st);
        chunk_res_t res;
        bit         has;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        sent_cnt++;
        has = decode_byte(b, st, res);
        if (row_chk == CHK_RES) due_results = {due_results, row_res};
        else if (row_chk == CHK_MODEL && has) due_results = {due_results, res};
    endtask

    // Waits until every due result has come, plus a margin for bytes still in flight.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_strict(input logic v);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hcbd_pkg::ADDR_STRICT_CRLF;
        pwdata  <= {31'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pred_strict = v;
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[0] !== v) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("%0t: strict_crlf read back %0b, expected %0b", $time, prdata[0], v);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(1, 0) ? 8'h61 : 8'h41) + v - 8'd10;
    endfunction

    // Occasionally replaces a framing byte with garbage.
    function automatic logic [7:0] noisy(input logic [7:0] b);
        return ($urandom_range(99) < 3) ? 8'($urandom) : b;
    endfunction

    task automatic send_size_line(input int sz, input logic opener);
        int         nd;
        logic       st;
        logic [7:0] xb;
        st = opener;
        if ($urandom_range(19) == 0) begin
            // Too many significant digits: the block must flag an overflow.
            nd = $urandom_range(10, 9);
            for (int i = 0; i < nd; i++) begin
                push_byte(hex_char((i == 0) ? 4'($urandom_range(15, 1)) : 4'($urandom)), st);
                st = 1'b0;
            end
        end
        nd = 0;
        for (int v = sz; v != 0; v = v >> 4) nd++;
        if (sz != 0 || $urandom_range(3) != 0) nd = ((nd == 0) ? 1 : nd) + $urandom_range(2, 0);
        for (int i = nd - 1; i >= 0; i--) begin
            push_byte(noisy(hex_char(4'(sz >> (4 * i)))), st);
            st = 1'b0;
        end
        if ($urandom_range(4) == 0) begin
            push_byte(";", st);
            st = 1'b0;
            repeat ($urandom_range(4, 0)) begin
                xb = 8'($urandom);
                push_byte((xb == hcbd_pkg::CH_CR) ? 8'h78 : xb, 1'b0);
            end
        end
        push_byte(noisy(hcbd_pkg::CH_CR), st);
        push_byte(noisy(hcbd_pkg::CH_LF), 1'b0);
    endtask

    task automatic send_message();
        int   sz;
        logic opener;
        opener = 1'b1;
        repeat ($urandom_range(3, 0)) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
            send_size_line(sz, opener);
            opener = 1'b0;
            repeat (sz) push_byte(8'($urandom), $urandom_range(199) == 0);
            push_byte(noisy(hcbd_pkg::CH_CR), 1'b0);
            push_byte(noisy(hcbd_pkg::CH_LF), 1'b0);
        end
        send_size_line(0, opener);
        // Trailing bytes after the end of the message are ignored.
        if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) push_byte(8'($urandom), 1'b0);
    endtask

    // Long receiver hold-off, counted here so the sender can keep pushing meanwhile.
    always @(posedge aclk) begin
        if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
        else if (hold_req) hold_cnt <= 400;
    end

    always @(posedge aclk) begin
        m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        chunk_res_t got;
        chunk_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata, m_tuser, m_tlast};
            if (due_results.size() == 0) begin
                note_mismatch("result with none due", '0, got);
            end else begin
                want = due_results.pop_front();
                if (got.data !== want.data || got.kind !== want.kind || got.last !== want.last)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    initial begin
        int  target;
        bit  paused;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 25; i++) begin
            if (DIRECTED_TBL[i].cfg != CFG_KEEP) set_strict(DIRECTED_TBL[i].cfg == CFG_STRICT);
            row_chk = DIRECTED_TBL[i].chk;
            row_res = DIRECTED_TBL[i].res;
            push_byte(DIRECTED_TBL[i].b, DIRECTED_TBL[i].st);
        end
        row_chk = CHK_MODEL;

        paused = 1'b0;
        for (int p = 0; p < 5; p++) begin
            set_strict(p % 2 == 1);
            idle_pct = SEND_IDLE[p];
            stall_pct <= RECV_STALL[p];
            if (p == 4) begin
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
            end
            target = sent_cnt + 100;
            while (sent_cnt < target) begin
                send_message();
                // Halfway through the last phase the sender waits for the block to drain.
                if (p == 4 && !paused && sent_cnt > target - 50) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end

        wait_idle();
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
